// ===== sv/resource_quota_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// resource quota limiter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RESOURCE_QUOTA_LIMITER_DEFINES_SVH
`define RESOURCE_QUOTA_LIMITER_DEFINES_SVH

// same-cycle implication
`define RQL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RQL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rql_pkg.sv =====
// ----------------------------------------------------------------------------
// rql_pkg
// types, codes and constants of the resource quota limiter
// ----------------------------------------------------------------------------
package rql_pkg;

	localparam int unsigned VAL_W    = 32;
	localparam int unsigned CFG_W    = 36;
	localparam int unsigned SLOT_W   = 9;
	localparam int unsigned MAX_SLOTS = 8;
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned SCALED_W = VAL_W + 7;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_RESET   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_MEMORY  = 2'd0,
		RES_CPU     = 2'd1,
		RES_IO      = 2'd2,
		RES_INVALID = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EXCEEDED = 2'd1,
		STAT_INVALID  = 2'd2
	} stat_t;

	localparam logic [2:0] REG_MEMORY_QUOTA    = 3'd0;
	localparam logic [2:0] REG_CPU_LIMIT       = 3'd1;
	localparam logic [2:0] REG_IO_LIMIT        = 3'd2;
	localparam logic [2:0] REG_ENFORCE_LIMITS  = 3'd3;
	localparam logic [2:0] REG_THRESHOLD_COUNT = 3'd4;
	localparam logic [2:0] REG_THRESHOLDS_LOW  = 3'd5;
	localparam logic [2:0] REG_THRESHOLDS_HIGH = 3'd6;

	localparam logic [VAL_W-1:0] MEMORY_QUOTA_RST = 32'd10485760;
	localparam logic [VAL_W-1:0] CPU_LIMIT_RST    = 32'd1000;
	localparam logic [VAL_W-1:0] IO_LIMIT_RST     = 32'd1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} top_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_SAT,
		DIV_STEP
	} div_state_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] usage;
		logic [VAL_W-1:0] quota;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] pct;
	} div_rsp_t;

endpackage

// ===== sv/rql_div.sv =====
// ----------------------------------------------------------------------------
// rql_div
// serial percentage unit: floor(usage*100/quota), saturated to 255,
// one shared compare-subtract per cycle
// ----------------------------------------------------------------------------
module rql_div
	import rql_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	div_state_t state_q, state_d;

	logic [VAL_W-1:0]    usage_q;
	logic [VAL_W-1:0]    quota_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [VAL_W-1:0]    rem_q;
	logic [7:0]          lo_q;
	logic [7:0]          quo_q;
	logic [2:0]          cnt_q;
	logic                done_q;

	logic [VAL_W:0]   trial;
	logic [VAL_W+1:0] diff;
	logic             ge;
	logic             load_en;
	logic             step_en;

	// shared compare-subtract
	always_comb begin
		if (state_q == DIV_SAT) begin
			trial = (VAL_W+1)'(scaled_q[SCALED_W-1:8]);
		end else begin
			trial = {rem_q, lo_q[7]};
		end
		diff = {1'b0, trial} - {2'b00, quota_q};
		ge   = !diff[VAL_W+1];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (req.start) begin
					state_d = DIV_LOAD;
				end
			end
			DIV_LOAD: state_d = DIV_SAT;
			DIV_SAT: begin
				if (ge) begin
					state_d = DIV_IDLE;
				end else begin
					state_d = DIV_STEP;
				end
			end
			DIV_STEP: begin
				if (cnt_q == 3'd0) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		load_en = 1'b0;
		step_en = 1'b0;
		case (state_q)
			DIV_IDLE: load_en = req.start;
			DIV_STEP: step_en = 1'b1;
			default: begin
				load_en = 1'b0;
				step_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == DIV_SAT) && ge) || (step_en && (cnt_q == 3'd0));
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			usage_q <= req.usage;
			quota_q <= req.quota;
		end
		if (state_q == DIV_LOAD) begin
			scaled_q <= SCALED_W'(usage_q) * SCALED_W'(PCT_SCALE);
		end
		if (state_q == DIV_SAT) begin
			rem_q <= VAL_W'(scaled_q[SCALED_W-1:8]);
			lo_q  <= scaled_q[7:0];
			cnt_q <= 3'd7;
			quo_q <= ge ? 8'hFF : 8'h00;
		end
		if (step_en) begin
			rem_q <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			lo_q  <= {lo_q[6:0], 1'b0};
			quo_q <= {quo_q[6:0], ge};
			cnt_q <= cnt_q - 3'd1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.pct  = quo_q;

endmodule

// ===== sv/resource_quota_limiter.sv =====
// successful allocate against a nonzero quota: execute, the serial percentage unit, then done,
// where saturation skips the bit steps; every other command: execute, then done
// one item at a time; the serial percentage unit gives one quotient bit a cycle; the next
// item is taken while a result waits on the output
// asynchronous reset clears counters, peaks and control and loads the register defaults
// ----------------------------------------------------------------------------
// resource_quota_limiter
// per-resource usage and peak tracking with quota check, event counters and
// percentage threshold hits
// ----------------------------------------------------------------------------
module resource_quota_limiter
	import rql_pkg::*;
#(
	parameter int THRESHOLD_SLOTS = 8,
	parameter int COUNT_WIDTH     = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       cmd,
	input  logic [1:0]       resource,
	input  logic [VAL_W-1:0] amount,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [VAL_W-1:0] usage_now,
	output logic [VAL_W-1:0] usage_peak,
	output logic [7:0]       threshold_hits,
	output logic [VAL_W-1:0] violation_total,
	output logic [VAL_W-1:0] alloc_total,
	output logic [VAL_W-1:0] free_total
);

	// configuration
	logic [VAL_W-1:0]  mem_quota_q, cpu_lim_q, io_lim_q;
	logic              enforce_q;
	logic [3:0]        thr_count_q;
	logic [CFG_W-1:0]  thr_low_q, thr_high_q;

	// state
	logic [VAL_W-1:0]       usage_q [3];
	logic [VAL_W-1:0]       peak_q [3];
	logic [COUNT_WIDTH-1:0] viol_cnt_q, alloc_cnt_q, free_cnt_q;

	// item
	top_state_t       state_q, state_d;
	cmd_t             cmd_q;
	res_t             res_q;
	logic [VAL_W-1:0] amt_q;
	stat_t            stat_q;
	logic [7:0]       hits_q;

	// output register
	logic             out_valid_q;
	stat_t            status_q;
	logic [VAL_W-1:0] usage_now_q, usage_peak_q;
	logic [7:0]       hits_out_q;
	logic [VAL_W-1:0] viol_out_q, alloc_out_q, free_out_q;

	logic             accept;
	logic             out_free;
	logic             exec_en;
	logic             done_en;
	logic             res_ok;
	logic [VAL_W-1:0] quota_sel;
	logic [VAL_W-1:0] cur_usage, cur_peak;
	logic [VAL_W:0]   sum;
	logic [VAL_W-1:0] sum_sat;
	logic [VAL_W-1:0] rel_val;
	logic             over;
	logic             is_alloc, is_release, alloc_ok, need_div;
	logic [2*CFG_W-1:0] thr_all;
	logic [SLOT_W-1:0]  slot;
	logic [7:0]         hits_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_quota_q <= MEMORY_QUOTA_RST;
			cpu_lim_q   <= CPU_LIMIT_RST;
			io_lim_q    <= IO_LIMIT_RST;
			enforce_q   <= 1'b1;
			thr_count_q <= '0;
			thr_low_q   <= '0;
			thr_high_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MEMORY_QUOTA:    mem_quota_q <= cfg_data[VAL_W-1:0];
				REG_CPU_LIMIT:       cpu_lim_q   <= cfg_data[VAL_W-1:0];
				REG_IO_LIMIT:        io_lim_q    <= cfg_data[VAL_W-1:0];
				REG_ENFORCE_LIMITS:  enforce_q   <= cfg_data[0];
				REG_THRESHOLD_COUNT: thr_count_q <= cfg_data[3:0];
				REG_THRESHOLDS_LOW:  thr_low_q   <= cfg_data;
				REG_THRESHOLDS_HIGH: thr_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// addressed resource
	always_comb begin
		res_ok = (res_q != RES_INVALID);
		case (res_q)
			RES_MEMORY: begin
				quota_sel = mem_quota_q;
				cur_usage = usage_q[0];
				cur_peak  = peak_q[0];
			end
			RES_CPU: begin
				quota_sel = cpu_lim_q;
				cur_usage = usage_q[1];
				cur_peak  = peak_q[1];
			end
			RES_IO: begin
				quota_sel = io_lim_q;
				cur_usage = usage_q[2];
				cur_peak  = peak_q[2];
			end
			default: begin
				quota_sel = io_lim_q;
				cur_usage = '0;
				cur_peak  = '0;
			end
		endcase
	end

	// quota check and update values
	always_comb begin
		sum        = {1'b0, cur_usage} + {1'b0, amt_q};
		sum_sat    = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
		over       = enforce_q && (quota_sel != '0) && (sum > {1'b0, quota_sel});
		rel_val    = (amt_q > cur_usage) ? '0 : cur_usage - amt_q;
		is_alloc   = (cmd_q == CMD_ALLOC) && res_ok;
		is_release = (cmd_q == CMD_RELEASE) && res_ok;
		alloc_ok   = is_alloc && !over;
		need_div   = alloc_ok && (quota_sel != '0);
	end

	// threshold slots against the percentage
	assign thr_all = {thr_high_q, thr_low_q};

	always_comb begin
		hits_d = '0;
		slot   = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot = thr_all[SLOT_W*i +: SLOT_W];
			if ((i < THRESHOLD_SLOTS) && (4'(i) < thr_count_q) && (slot[8:7] == res_q) &&
					(div_rsp.pct >= {1'b0, slot[6:0]})) begin
				hits_d[i] = 1'b1;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (need_div) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		exec_en       = 1'b0;
		done_en       = 1'b0;
		div_req.start = 1'b0;
		div_req.usage = sum_sat;
		div_req.quota = quota_sel;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_EXEC: begin
				exec_en       = 1'b1;
				div_req.start = need_div;
			end
			ST_DONE: done_en = out_free;
			default: begin
				in_stall = 1'b1;
				exec_en  = 1'b0;
			end
		endcase
	end

	rql_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			res_q <= res_t'(resource);
			amt_q <= amount;
		end
		if (exec_en) begin
			hits_q <= '0;
			if ((cmd_q == CMD_ALLOC || cmd_q == CMD_RELEASE) && !res_ok) begin
				stat_q <= STAT_INVALID;
			end else if (is_alloc && over) begin
				stat_q <= STAT_EXCEEDED;
			end else begin
				stat_q <= STAT_OK;
			end
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			hits_q <= hits_d;
		end
	end

	// usage, peak and event counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				usage_q[k] <= '0;
				peak_q[k]  <= '0;
			end
			viol_cnt_q  <= '0;
			alloc_cnt_q <= '0;
			free_cnt_q  <= '0;
		end else if (exec_en) begin
			if (cmd_q == CMD_RESET) begin
				for (int k = 0; k < 3; k++) begin
					usage_q[k] <= '0;
					peak_q[k]  <= '0;
				end
				viol_cnt_q  <= '0;
				alloc_cnt_q <= '0;
				free_cnt_q  <= '0;
			end else begin
				for (int k = 0; k < 3; k++) begin
					if (2'(k) == res_q) begin
						if (alloc_ok) begin
							usage_q[k] <= sum_sat;
							if (sum_sat > cur_peak) begin
								peak_q[k] <= sum_sat;
							end
						end else if (is_release) begin
							usage_q[k] <= rel_val;
						end
					end
				end
				if (is_alloc && over && (viol_cnt_q != '1)) begin
					viol_cnt_q <= viol_cnt_q + 1'b1;
				end
				if (alloc_ok && (res_q == RES_MEMORY) && (alloc_cnt_q != '1)) begin
					alloc_cnt_q <= alloc_cnt_q + 1'b1;
				end
				if (is_release && (res_q == RES_MEMORY) && (free_cnt_q != '1)) begin
					free_cnt_q <= free_cnt_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_en) begin
			status_q     <= stat_q;
			usage_now_q  <= cur_usage;
			usage_peak_q <= cur_peak;
			hits_out_q   <= hits_q;
			viol_out_q   <= VAL_W'(viol_cnt_q);
			alloc_out_q  <= VAL_W'(alloc_cnt_q);
			free_out_q   <= VAL_W'(free_cnt_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign usage_now       = usage_now_q;
	assign usage_peak      = usage_peak_q;
	assign threshold_hits  = hits_out_q;
	assign violation_total = viol_out_q;
	assign alloc_total     = alloc_out_q;
	assign free_total      = free_out_q;

endmodule

// ===== sv/rql_chk.sv =====
// ----------------------------------------------------------------------------
// rql_chk
// port-level checks of the resource quota limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "resource_quota_limiter_defines.svh"

module rql_chk
	import rql_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       status,
	input logic [VAL_W-1:0] usage_now,
	input logic [VAL_W-1:0] usage_peak,
	input logic [7:0]       threshold_hits
);

	// held result keeps its payload
	`RQL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(usage_now), "result changed while stalled")

	// one item in flight: a transfer in closes the input for the next cycle
	`RQL_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "input open right after a transfer")

	// no threshold hits on a failed command
	`RQL_ASSERT_SAME(a_hits_ok, out_valid && (status != STAT_OK), threshold_hits == 8'h00, "threshold hits on a failed command")

	// peak never below current usage
	`RQL_ASSERT_SAME(a_peak, out_valid, usage_peak >= usage_now, "peak below usage")

endmodule

bind resource_quota_limiter rql_chk u_rql_chk (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource quota limiter testbench
// walks a table of directed commands, then random commands under several
// quota and threshold settings; every result is checked against a table row
// or a local prediction of usage, peaks, event counters and threshold hits
// ----------------------------------------------------------------------------
module testbench;
	import rql_pkg::*;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] now;
		logic [VAL_W-1:0] peak;
		logic [7:0]       hits;
		logic [VAL_W-1:0] vio;
		logic [VAL_W-1:0] alloc;
		logic [VAL_W-1:0] free;
	} quota_result_t;

	typedef struct {
		bit               is_reg;
		logic [2:0]       reg_idx;
		logic [CFG_W-1:0] reg_val;
		cmd_t             c;
		res_t             r;
		logic [VAL_W-1:0] amt;
		bit               typed;
		quota_result_t    want;
	} step_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       cmd = '0;
	logic [1:0]       resource = '0;
	logic [VAL_W-1:0] amount = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       status;
	logic [VAL_W-1:0] usage_now;
	logic [VAL_W-1:0] usage_peak;
	logic [7:0]       threshold_hits;
	logic [VAL_W-1:0] violation_total;
	logic [VAL_W-1:0] alloc_total;
	logic [VAL_W-1:0] free_total;

	// register shadow
	logic [VAL_W-1:0] mem_quota = MEMORY_QUOTA_RST;
	logic [VAL_W-1:0] cpu_lim = CPU_LIMIT_RST;
	logic [VAL_W-1:0] io_lim = IO_LIMIT_RST;
	logic             enforce = 1'b1;
	logic [3:0]       thr_count = '0;
	logic [CFG_W-1:0] thr_low = '0;
	logic [CFG_W-1:0] thr_high = '0;

	// usage state
	logic [VAL_W-1:0] usage_q [3] = '{default: '0};
	logic [VAL_W-1:0] peak_q [3] = '{default: '0};
	logic [VAL_W-1:0] violations = '0;
	logic [VAL_W-1:0] allocs = '0;
	logic [VAL_W-1:0] frees = '0;

	quota_result_t pending_results [$];
	step_row_t     directed_steps [$];
	int            errors = 0;
	int            reported = 0;
	bit            calm = 1'b0;
	int            hold_requests = 0;
	int            holds_served = 0;
	int            hold_left = 0;

	resource_quota_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.resource(resource),
		.amount(amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.usage_now(usage_now),
		.usage_peak(usage_peak),
		.threshold_hits(threshold_hits),
		.violation_total(violation_total),
		.alloc_total(alloc_total),
		.free_total(free_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	function automatic logic [VAL_W-1:0] bump(input logic [VAL_W-1:0] cnt);
		return (cnt == '1) ? cnt : cnt + 1'b1;
	endfunction

	function automatic logic [8:0] mk_slot(input res_t r, input int pct);
		return {r, 7'(pct)};
	endfunction

	function automatic logic [7:0] threshold_hits_for(input res_t r,
			input logic [VAL_W-1:0] u, input logic [VAL_W-1:0] q);
		logic [SCALED_W-1:0] pct;
		logic [8:0]          slot;
		logic [7:0]          hits;
		int                  n;
		pct = ({7'd0, u} * PCT_SCALE) / {7'd0, q};
		if (pct > 255)
			pct = 255;
		n = (thr_count > MAX_SLOTS) ? MAX_SLOTS : int'(thr_count);
		hits = '0;
		for (int i = 0; i < n; i++) begin
			slot = (i < 4) ? thr_low[9*i +: 9] : thr_high[9*(i-4) +: 9];
			if (slot[8:7] == r && pct >= slot[6:0])
				hits[i] = 1'b1;
		end
		return hits;
	endfunction

	function automatic quota_result_t predict_outcome(input cmd_t c, input res_t r,
			input logic [VAL_W-1:0] amt);
		quota_result_t    res;
		logic [VAL_W:0]   total;
		logic [VAL_W-1:0] quota;
		int               idx;
		idx = (r == RES_INVALID) ? 0 : int'(r);
		res = '0;
		res.status = STAT_OK;
		quota = (r == RES_MEMORY) ? mem_quota : (r == RES_CPU) ? cpu_lim : io_lim;
		case (c)
			CMD_RESET: begin
				for (int k = 0; k < 3; k++) begin
					usage_q[k] = '0;
					peak_q[k] = '0;
				end
				violations = '0;
				allocs = '0;
				frees = '0;
			end
			CMD_ALLOC, CMD_RELEASE: begin
				if (r == RES_INVALID) begin
					res.status = STAT_INVALID;
				end else if (c == CMD_ALLOC) begin
					total = {1'b0, usage_q[idx]} + amt;
					if (enforce && quota != 0 && total > {1'b0, quota}) begin
						violations = bump(violations);
						res.status = STAT_EXCEEDED;
					end else begin
						usage_q[idx] = total[VAL_W] ? '1 : total[VAL_W-1:0];
						if (usage_q[idx] > peak_q[idx])
							peak_q[idx] = usage_q[idx];
						if (r == RES_MEMORY)
							allocs = bump(allocs);
						if (quota != 0)
							res.hits = threshold_hits_for(r, usage_q[idx], quota);
					end
				end else begin
					usage_q[idx] = (amt > usage_q[idx]) ? '0 : usage_q[idx] - amt;
					if (r == RES_MEMORY)
						frees = bump(frees);
				end
			end
			default: ;
		endcase
		if (r != RES_INVALID) begin
			res.now = usage_q[idx];
			res.peak = peak_q[idx];
		end
		res.vio = violations;
		res.alloc = allocs;
		res.free = frees;
		return res;
	endfunction

	function automatic void add_item(input cmd_t c, input res_t r, input logic [VAL_W-1:0] amt);
		step_row_t row;
		row = '{c: CMD_READ, r: RES_MEMORY, default: '0};
		row.c = c;
		row.r = r;
		row.amt = amt;
		directed_steps.push_back(row);
	endfunction

	function automatic void add_checked(input cmd_t c, input res_t r,
			input logic [VAL_W-1:0] amt, input stat_t s, input logic [VAL_W-1:0] now,
			input logic [VAL_W-1:0] peak, input logic [VAL_W-1:0] vio,
			input logic [VAL_W-1:0] alloc, input logic [VAL_W-1:0] free);
		step_row_t row;
		row = '{c: CMD_READ, r: RES_MEMORY, default: '0};
		row.c = c;
		row.r = r;
		row.amt = amt;
		row.typed = 1'b1;
		row.want = '{s, now, peak, 8'd0, vio, alloc, free};
		directed_steps.push_back(row);
	endfunction

	function automatic void add_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		step_row_t row;
		row = '{c: CMD_READ, r: RES_MEMORY, default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		directed_steps.push_back(row);
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MEMORY_QUOTA:    mem_quota = val[VAL_W-1:0];
			REG_CPU_LIMIT:       cpu_lim = val[VAL_W-1:0];
			REG_IO_LIMIT:        io_lim = val[VAL_W-1:0];
			REG_ENFORCE_LIMITS:  enforce = val[0];
			REG_THRESHOLD_COUNT: thr_count = val[3:0];
			REG_THRESHOLDS_LOW:  thr_low = val;
			REG_THRESHOLDS_HIGH: thr_high = val;
			default: ;
		endcase
	endtask

	task automatic send_item(input cmd_t c, input res_t r, input logic [VAL_W-1:0] amt,
			input bit typed, input quota_result_t want);
		quota_result_t predicted;
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		resource <= r;
		amount <= amt;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = predict_outcome(c, r, amt);
		pending_results.push_back(typed ? want : predicted);
	endtask

	function automatic logic [VAL_W-1:0] pick_quota();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(4000, 1);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_amount();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return $urandom_range(600);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_slots();
		logic [CFG_W-1:0] word;
		res_t             r;
		int               pct;
		for (int i = 0; i < 4; i++) begin
			r = ($urandom_range(7) == 0) ? RES_INVALID : res_t'($urandom_range(2));
			pct = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(100);
			word[9*i +: 9] = mk_slot(r, pct);
		end
		return word;
	endfunction

	// receiver side
	always @(posedge clk) begin
		if (hold_left == 0 && hold_requests != holds_served) begin
			holds_served = holds_served + 1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 32);
		end
	end

	// result check
	always @(posedge clk) begin
		quota_result_t got;
		quota_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			got = '{status, usage_now, usage_peak, threshold_hits, violation_total,
				alloc_total, free_total};
			if (pending_results.size() == 0) begin
				errors++;
				if (reported < 10)
					$display("unexpected result transfer: status %0d now %h", got.status, got.now);
				reported++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					if (reported < 10)
						$display({"mismatch exp/got: status %0d/%0d now %h/%h peak %h/%h ",
							"hits %h/%h vio %h/%h alloc %h/%h free %h/%h"},
							want.status, got.status, want.now, got.now,
							want.peak, got.peak, want.hits, got.hits, want.vio, got.vio,
							want.alloc, got.alloc, want.free, got.free);
					reported++;
				end
			end
		end
	end

	initial begin
		cmd_t             c;
		res_t             r;
		logic [VAL_W-1:0] amt;
		int               pick;

		// reset defaults, then plain commands and invalid resources
		add_checked(CMD_READ, RES_MEMORY, 32'd0, STAT_OK, 0, 0, 0, 0, 0);
		add_checked(CMD_ALLOC, RES_CPU, 32'd1000, STAT_OK, 1000, 1000, 0, 0, 0);
		add_checked(CMD_ALLOC, RES_CPU, 32'd1, STAT_EXCEEDED, 1000, 1000, 1, 0, 0);
		add_checked(CMD_RELEASE, RES_CPU, 32'hFFFF_FFFF, STAT_OK, 0, 1000, 1, 0, 0);
		add_checked(CMD_ALLOC, RES_MEMORY, 32'd0, STAT_OK, 0, 0, 1, 1, 0);
		add_checked(CMD_RELEASE, RES_MEMORY, 32'd0, STAT_OK, 0, 0, 1, 1, 1);
		add_checked(CMD_ALLOC, RES_INVALID, 32'hFFFF_FFFF, STAT_INVALID, 0, 0, 1, 1, 1);
		add_checked(CMD_RELEASE, RES_INVALID, 32'd5, STAT_INVALID, 0, 0, 1, 1, 1);
		add_checked(CMD_READ, RES_CPU, 32'hA5A5_A5A5, STAT_OK, 0, 1000, 1, 1, 1);
		add_checked(CMD_ALLOC, RES_IO, 32'hFFFF_FFFF, STAT_EXCEEDED, 0, 0, 2, 1, 1);
		add_checked(CMD_RESET, RES_INVALID, 32'h1234_5678, STAT_OK, 0, 0, 0, 0, 0);
		add_checked(CMD_READ, RES_INVALID, 32'd0, STAT_OK, 0, 0, 0, 0, 0);
		// thresholds, slot count above the slot number, percent saturation
		add_reg(REG_ENFORCE_LIMITS, 36'd0);
		add_reg(REG_MEMORY_QUOTA, 36'd0);
		add_reg(REG_CPU_LIMIT, 36'd200);
		add_reg(REG_IO_LIMIT, 36'hF_FFFF_FFFF);
		add_reg(REG_THRESHOLD_COUNT, 36'd9);
		add_reg(REG_THRESHOLDS_LOW, {mk_slot(RES_INVALID, 0), mk_slot(RES_CPU, 100),
			mk_slot(RES_CPU, 50), mk_slot(RES_IO, 0)});
		add_reg(REG_THRESHOLDS_HIGH, {mk_slot(RES_MEMORY, 1), mk_slot(RES_IO, 100),
			mk_slot(RES_CPU, 127), mk_slot(RES_MEMORY, 127)});
		add_item(CMD_ALLOC, RES_CPU, 32'd100);
		add_item(CMD_ALLOC, RES_CPU, 32'd100);
		add_item(CMD_ALLOC, RES_CPU, 32'hFFFF_FFFF);
		add_item(CMD_ALLOC, RES_IO, 32'hFFFF_FFFF);
		add_item(CMD_ALLOC, RES_MEMORY, 32'hFFFF_FFFF);
		add_item(CMD_RELEASE, RES_MEMORY, 32'd1);
		add_item(CMD_READ, RES_IO, 32'd0);
		add_reg(REG_ENFORCE_LIMITS, 36'd1);
		add_reg(REG_MEMORY_QUOTA, 36'd1000);
		add_reg(REG_THRESHOLDS_HIGH, 36'hF_FFFF_FFFF);
		add_reg(REG_THRESHOLD_COUNT, 36'd15);
		add_item(CMD_RESET, RES_MEMORY, 32'd0);
		add_item(CMD_ALLOC, RES_MEMORY, 32'd10);
		add_item(CMD_ALLOC, RES_IO, 32'd1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_reg) begin
				wait_drained();
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
			end else begin
				send_item(directed_steps[i].c, directed_steps[i].r, directed_steps[i].amt,
					directed_steps[i].typed, directed_steps[i].want);
			end
		end

		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			if (phase == 0) begin
				write_reg(REG_MEMORY_QUOTA, 36'hF_FFFF_FFFF);
				write_reg(REG_CPU_LIMIT, 36'hF_FFFF_FFFF);
				write_reg(REG_IO_LIMIT, 36'hF_FFFF_FFFF);
				write_reg(REG_ENFORCE_LIMITS, 36'd1);
				write_reg(REG_THRESHOLD_COUNT, 36'd8);
			end else if (phase == 1) begin
				write_reg(REG_MEMORY_QUOTA, 36'd0);
				write_reg(REG_CPU_LIMIT, 36'd0);
				write_reg(REG_IO_LIMIT, 36'd0);
				write_reg(REG_ENFORCE_LIMITS, 36'd0);
				write_reg(REG_THRESHOLD_COUNT, 36'd0);
			end else begin
				write_reg(REG_MEMORY_QUOTA, {4'($urandom), pick_quota()});
				write_reg(REG_CPU_LIMIT, {4'($urandom), pick_quota()});
				write_reg(REG_IO_LIMIT, {4'($urandom), pick_quota()});
				write_reg(REG_ENFORCE_LIMITS,
					{$urandom, 3'($urandom), 1'($urandom_range(3) != 0)});
				write_reg(REG_THRESHOLD_COUNT, {$urandom, 4'($urandom_range(15))});
			end
			write_reg(REG_THRESHOLDS_LOW, pick_slots());
			write_reg(REG_THRESHOLDS_HIGH, pick_slots());
			calm = (phase == 3);
			if (phase == 1)
				hold_requests++;
			for (int n = 0; n < 75; n++) begin
				if (phase == 2 && n == 40)
					wait_drained();
				pick = $urandom_range(99);
				c = (pick < 50) ? CMD_ALLOC : (pick < 75) ? CMD_RELEASE :
					(pick < 80) ? CMD_RESET : CMD_READ;
				r = ($urandom_range(11) == 0) ? RES_INVALID : res_t'($urandom_range(2));
				amt = pick_amount();
				send_item(c, r, amt, 1'b0, '0);
			end
			calm = 1'b0;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/rql_pkg.sv
sv/rql_div.sv
sv/resource_quota_limiter.sv
sv/rql_chk.sv
tb/sv/testbench.sv
